// ===== hw/rtl/key_escape_sequence_matcher_top_assert.svh =====
// ---------------------------------------------------------------------------
// key escape sequence matcher assertion macros
// concurrent assertion wrappers sampled on clk, with and without reset gating
// ---------------------------------------------------------------------------
`ifndef KEY_ESCAPE_SEQUENCE_MATCHER_TOP_ASSERT_SVH
`define KEY_ESCAPE_SEQUENCE_MATCHER_TOP_ASSERT_SVH

// checked only outside reset
`define KESM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked also while reset is high
`define KESM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kesm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kesm_pkg
// opcodes, scan verdict codes and the controller/datapath command and status
// ---------------------------------------------------------------------------
package kesm_pkg;

  localparam logic [1:0] OP_LOAD_SEQ = 2'd0;
  localparam logic [1:0] OP_LOAD_KEY = 2'd1;
  localparam logic [1:0] OP_RECV     = 2'd2;
  localparam logic [1:0] OP_TICK     = 2'd3;

  // outcome of checking one table entry
  localparam logic [1:0] C_SKIP = 2'd0;
  localparam logic [1:0] C_WAIT = 2'd1;
  localparam logic [1:0] C_HIT  = 2'd2;
  localparam logic [1:0] C_MISS = 2'd3;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic append;
    logic scan_start;
    logic rd;
    logic next_key;
    logic latch_chk;
    logic set_miss;
    logic set_zero;
    logic act;
    logic drop;
    logic fin;
  } kesm_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] op;
    logic       data_zero;
    logic       n_zero;
    logic       m_eq_n;
    logic       m_zero;
    logic [1:0] chk;
    logic       last_key;
    logic       can_push;
    logic       out_free;
    logic       hold_valid;
  } kesm_stat_t;

endpackage

// ===== hw/rtl/kesm_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kesm channel interfaces
// valid/ready channels for input items and result items
// ---------------------------------------------------------------------------
interface kesm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] key_slot;
  logic [2:0] byte_position;
  logic [7:0] data_value;

  modport source (output valid, opcode, key_slot, byte_position, data_value, input ready);
  modport sink   (input valid, opcode, key_slot, byte_position, data_value, output ready);
endinterface

interface kesm_out_if;
  logic       valid;
  logic       ready;
  logic       is_key;
  logic [7:0] out_value;
  logic       last_of_run;

  modport source (output valid, is_key, out_value, last_of_run, input ready);
  modport sink   (input valid, is_key, out_value, last_of_run, output ready);
endinterface

// ===== hw/rtl/key_escape_sequence_matcher_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_escape_sequence_matcher_top
// decodes received terminal bytes into key codes against a loaded table
// ---------------------------------------------------------------------------
// in_ch takes load items (sequence byte, key code), received bytes and
// timeout ticks; out_ch gives key codes or plain bytes, last_of_run marking
// the final result of an input item. cfg_we/cfg_data write mapping_enable.
// One item is worked on at a time: in_ch is ready only while idle.
// Loads and a tick on an empty buffer finish while idle. Each matcher step
// visits table entries in turn, each by a registered row read and then a
// check; a step that resolves hands off its result and then drops the
// matched bytes (none after a miss). A received byte or flush ends by way
// of S_LOOP and then S_FIN before in_ch is ready again. Results are held
// one deep so the last can be marked; the first result appears after the
// second is found or the run ends. A stalled out_ch holds its item and the
// sequencer waits before pushing another. Reset clears the pending buffer,
// key codes and mapping_enable and empties the output; the sequence table
// is left as it was.
// ---------------------------------------------------------------------------
module key_escape_sequence_matcher_top #(
  parameter int NUM_KEYS = 8,
  parameter int SEQ_LEN  = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  kesm_in_if.sink    in_ch,
  kesm_out_if.source out_ch
);
  import kesm_pkg::*;

  kesm_cmd_t  cmd;
  kesm_stat_t stat;

  kesm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  kesm_dp #(
    .NUM_KEYS (NUM_KEYS),
    .SEQ_LEN  (SEQ_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== hw/rtl/kesm_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kesm_ctrl
// sequencer: takes an item, steps the pending buffer through the table scan
// ---------------------------------------------------------------------------
module kesm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  kesm_pkg::kesm_stat_t  stat,
  output kesm_pkg::kesm_cmd_t   cmd
);
  import kesm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_ACT  = 3'd4;
  localparam logic [2:0] S_DROP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          unique case (stat.op)
            OP_LOAD_SEQ, OP_LOAD_KEY: begin
              cmd.load = 1'b1;
            end
            OP_RECV: begin
              if (!stat.data_zero) begin
                cmd.append = 1'b1;
                state_next = S_LOOP;
              end else if (stat.n_zero) begin
                cmd.set_zero = 1'b1;
                state_next   = S_ACT;
              end else begin
                cmd.set_miss = 1'b1;
                state_next   = S_ACT;
              end
            end
            OP_TICK: begin
              if (!stat.n_zero) begin
                cmd.set_miss = 1'b1;
                state_next   = S_ACT;
              end
            end
          endcase
        end
      end
      S_LOOP: begin
        if (stat.m_eq_n) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        unique case (stat.chk)
          C_SKIP: begin
            if (stat.last_key) begin
              cmd.set_miss = 1'b1;
              state_next   = S_ACT;
            end else begin
              cmd.next_key = 1'b1;
              state_next   = S_RD;
            end
          end
          C_WAIT: begin
            state_next = S_LOOP;
          end
          C_HIT, C_MISS: begin
            cmd.latch_chk = 1'b1;
            state_next    = S_ACT;
          end
        endcase
      end
      S_ACT: begin
        if (stat.can_push) begin
          cmd.act    = 1'b1;
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        if (stat.m_zero) begin
          state_next = S_LOOP;
        end else begin
          cmd.drop = 1'b1;
        end
      end
      S_FIN: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/kesm_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kesm_dp
// table memory, key codes, pending buffer, entry check, result hold and output
// ---------------------------------------------------------------------------
module kesm_dp #(
  parameter int NUM_KEYS = 8,
  parameter int SEQ_LEN  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  kesm_in_if.sink               in_ch,
  kesm_out_if.source            out_ch,
  input  kesm_pkg::kesm_cmd_t   cmd,
  output kesm_pkg::kesm_stat_t  stat
);
  import kesm_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PW = $clog2(SEQ_LEN);
  localparam int CW = $clog2(SEQ_LEN + 1);

  localparam logic [1:0] V_MISS = 2'd0;
  localparam logic [1:0] V_HIT  = 2'd1;
  localparam logic [1:0] V_ZERO = 2'd2;

  logic                    mapping_enable;
  logic [SEQ_LEN-1:0][7:0] row_mem [NUM_KEYS];
  logic [SEQ_LEN-1:0][7:0] row_q;
  logic [7:0]    key_codes [NUM_KEYS];
  logic [7:0]    kc_q;
  logic [7:0]    q [SEQ_LEN];
  logic [CW-1:0] n;
  logic [CW-1:0] m;
  logic [KW-1:0] k;
  logic [1:0]    verdict;
  logic [7:0]    hit_code;
  logic          hold_valid;
  logic          hold_key;
  logic [7:0]    hold_val;
  logic          out_valid;
  logic          out_key;
  logic [7:0]    out_val;
  logic          out_last;

  logic [KW+2:0] slot_ext;
  logic [PW+2:0] pos_ext;
  logic          slot_ok;
  logic          pos_ok;
  logic          load_seq;
  logic          load_key;
  logic [CW-1:0] row_len;
  logic          prefix_ok;
  logic [1:0]    chk;
  logic          res_key;
  logic [7:0]    res_val;
  logic          shift_one;

  assign slot_ext  = (KW+3)'(in_ch.key_slot);
  assign pos_ext   = (PW+3)'(in_ch.byte_position);
  assign slot_ok   = int'(in_ch.key_slot) < NUM_KEYS;
  assign pos_ok    = int'(in_ch.byte_position) < SEQ_LEN;
  assign load_seq  = cmd.load && (in_ch.opcode == OP_LOAD_SEQ) && slot_ok && pos_ok;
  assign load_key  = cmd.load && (in_ch.opcode == OP_LOAD_KEY) && slot_ok;
  assign shift_one = (cmd.act && (verdict == V_MISS)) || cmd.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_enable <= 1'b0;
    end else if (cfg_we) begin
      mapping_enable <= cfg_data;
    end
  end

  // sequence table, one row per key, byte writes, registered row read
  always_ff @(posedge clk) begin
    if (load_seq) begin
      row_mem[slot_ext[KW-1:0]][pos_ext[PW-1:0]] <= in_ch.data_value;
    end
    if (cmd.rd) begin
      row_q <= row_mem[k];
      kc_q  <= key_codes[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_codes[i] <= 8'd0;
      end
    end else if (load_key) begin
      key_codes[slot_ext[KW-1:0]] <= in_ch.data_value;
    end
  end

  // check of one table entry against the first m pending bytes
  always_comb begin
    row_len = CW'(SEQ_LEN);
    for (int i = SEQ_LEN - 1; i >= 0; i--) begin
      if (row_q[i] == 8'd0) begin
        row_len = CW'(i);
      end
    end
    prefix_ok = 1'b1;
    for (int i = 0; i < SEQ_LEN; i++) begin
      if ((CW'(i) < m) && (q[i] != row_q[i])) begin
        prefix_ok = 1'b0;
      end
    end
    priority if (!mapping_enable || (kc_q == 8'd0)) begin
      chk = C_MISS;
    end else if ((m > row_len) || !prefix_ok) begin
      chk = C_SKIP;
    end else if (m == row_len) begin
      chk = C_HIT;
    end else begin
      chk = C_WAIT;
    end
  end

  always_comb begin
    unique case (verdict)
      V_HIT: begin
        res_key = 1'b1;
        res_val = hit_code;
      end
      V_ZERO: begin
        res_key = 1'b0;
        res_val = 8'd0;
      end
      default: begin
        res_key = 1'b0;
        res_val = q[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= '0;
      m          <= '0;
      k          <= '0;
      verdict    <= V_MISS;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.fin || (cmd.act && hold_valid)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.append) begin
        n <= n + 1'b1;
      end
      if (cmd.scan_start) begin
        m <= m + 1'b1;
        k <= '0;
      end
      if (cmd.next_key) begin
        k <= k + 1'b1;
      end
      if (cmd.latch_chk) begin
        verdict <= (chk == C_HIT) ? V_HIT : V_MISS;
      end
      if (cmd.set_miss) begin
        verdict <= V_MISS;
      end
      if (cmd.set_zero) begin
        verdict <= V_ZERO;
      end
      if (cmd.act) begin
        hold_valid <= 1'b1;
        if (verdict == V_MISS) begin
          n <= n - 1'b1;
          m <= '0;
        end
      end
      if (cmd.drop) begin
        n <= n - 1'b1;
        m <= m - 1'b1;
      end
      if (cmd.fin) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_chk) begin
      hit_code <= kc_q;
    end
    if (cmd.append) begin
      for (int i = 0; i < SEQ_LEN; i++) begin
        if (CW'(i) == n) begin
          q[i] <= in_ch.data_value;
        end
      end
    end
    if (shift_one) begin
      for (int i = 0; i < SEQ_LEN - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
    if (cmd.act) begin
      hold_key <= res_key;
      hold_val <= res_val;
      if (hold_valid) begin
        out_key  <= hold_key;
        out_val  <= hold_val;
        out_last <= 1'b0;
      end
    end
    if (cmd.fin) begin
      out_key  <= hold_key;
      out_val  <= hold_val;
      out_last <= 1'b1;
    end
  end

  assign in_ch.ready        = cmd.in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.is_key      = out_key;
  assign out_ch.out_value   = out_val;
  assign out_ch.last_of_run = out_last;

  always_comb begin
    stat.in_valid   = in_ch.valid;
    stat.op         = in_ch.opcode;
    stat.data_zero  = (in_ch.data_value == 8'd0);
    stat.n_zero     = (n == '0);
    stat.m_eq_n     = (m == n);
    stat.m_zero     = (m == '0);
    stat.chk        = chk;
    stat.last_key   = (k == KW'(NUM_KEYS - 1));
    stat.can_push   = !hold_valid || !out_valid || out_ch.ready;
    stat.out_free   = !out_valid || out_ch.ready;
    stat.hold_valid = hold_valid;
  end

endmodule

// ===== hw/rtl/kesm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kesm_checker
// port-level checks on the matcher, bound to the top level
// ---------------------------------------------------------------------------
`include "key_escape_sequence_matcher_top_assert.svh"

module kesm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic [7:0] in_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_key,
  input logic [7:0] out_value,
  input logic       out_last
);
  import kesm_pkg::*;

  `KESM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_is_key) && $stable(out_value) && $stable(out_last), "stalled result item changed")
  `KESM_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result item present after reset")
  `KESM_ASSERT(a_busy_after_byte, in_valid && in_ready && (in_opcode == OP_RECV) && (in_data != 8'd0) |=> !in_ready, "ready stayed high while matching a byte")
  `KESM_ASSERT(a_key_nonzero, out_valid && out_is_key |-> out_value != 8'd0, "key result with zero code")

endmodule

bind key_escape_sequence_matcher_top kesm_checker u_kesm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .in_data    (in_ch.data_value),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_is_key (out_ch.is_key),
  .out_value  (out_ch.out_value),
  .out_last   (out_ch.last_of_run)
);
